@@ rtl/core/next_fit_boundary_tag_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef NEXT_FIT_BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define NFA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define NFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/nfa_pkg.sv @@
// Package with the sequencer states and the codes of the allocator.
`timescale 1ns / 1ps
`default_nettype none
package nfa_pkg;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_NO_MEM  = 2'd2;

  // Tag layout and heap constants in bytes.
  localparam int unsigned ALLOC_BIT     = 1;
  localparam int unsigned SIZE_LOW_MASK = 7;
  localparam int unsigned MIN_BLOCK     = 16;
  localparam int unsigned HEAP_BASE     = 8;
  localparam int unsigned FIRST_PAYLOAD = 16;
  localparam int unsigned SMALL_REQ     = 8;
  localparam int unsigned OVERHEAD_UP   = 15;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_GROW,
    ST_GWR,
    ST_FRD,
    ST_FCHK,
    ST_FWR,
    ST_MR1,
    ST_MR2,
    ST_MR3,
    ST_MR4,
    ST_MWR,
    ST_CARVE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/nfa_tag_ram.sv @@
// Single-port tag word memory with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module nfa_tag_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int TW    = 17
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [TW-1:0] wdata,
  output logic      [TW-1:0] rdata
);

  logic [TW-1:0] mem [DEPTH];

  // One access a cycle: a write, or a read whose data shows the next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/next_fit_boundary_tag_allocator.sv @@
// Top level of the next-fit boundary-tag heap allocator.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    mode, request_bytes, block_address
//  out      output     out_valid/out_stall  payload_address, status
//
// The tag memory port is the only path to the heap, and a tag read is registered.
// An allocate walks the blocks from the rover, then splits, or grows, merges and
// splits; a free checks the tag, writes it and merges; each request ends in DONE.
// After reset a clearing pass writes all HEAP_BYTES/4 tag words of the initial
// heap with in_stall high. A stalled result waits in the output register while
// the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "next_fit_boundary_tag_allocator_assert.svh"
module next_fit_boundary_tag_allocator #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [15:0] request_bytes,
  input  wire logic [15:0] block_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] payload_address,
  output logic      [1:0]  status
);

  localparam int HW       = $clog2(HEAP_BYTES);
  localparam int DEPTH    = HEAP_BYTES / 4;
  localparam int AW       = $clog2(DEPTH);
  localparam int TW       = HW + 1;
  localparam int PW       = (HW + 2 > 18) ? HW + 2 : 18;
  localparam int LIMIT    = HEAP_BYTES / 8 + 2;
  localparam int CW       = $clog2(LIMIT + 1);
  localparam int CHUNK_R  = ((CHUNK_BYTES + 7) / 8) * 8;
  localparam bit INIT_OK  = (CHUNK_R <= HEAP_BYTES - 16);
  localparam int TOP0     = INIT_OK ? 16 + CHUNK_R : 16;
  localparam int ROVER0   = INIT_OK ? 16 : 8;
  localparam int IDX_FOOT = (8 + CHUNK_R) / 4;
  localparam int IDX_EPI  = (12 + CHUNK_R) / 4;

  nfa_pkg::state_t state, state_next;

  logic [PW-1:0] heap_top, rover, bp, need, size, nsize, pfoot, tot;
  logic [PW-1:0] res_addr;
  logic [1:0]    res_status;
  logic          palloc, nalloc, phase, is_grow;
  logic [CW-1:0] cnt;
  logic [1:0]    wstep;
  logic [AW-1:0] clr_idx;

  logic          mem_en, mem_we;
  logic [PW-1:0] mem_byte;
  logic [AW-1:0] mem_idx;
  logic [TW-1:0] mem_wdata, rdata;

  // Word the clearing pass leaves at each index: prologue, chunk, epilogue.
  function automatic logic [TW-1:0] init_word(input logic [AW-1:0] idx);
    logic [TW-1:0] w;
    w = '0;
    if (idx == AW'(1) || idx == AW'(2)) begin
      w = TW'(8 + nfa_pkg::ALLOC_BIT);
    end else if (INIT_OK && (idx == AW'(3) || idx == AW'(IDX_FOOT))) begin
      w = TW'(CHUNK_R);
    end else if ((INIT_OK && idx == AW'(IDX_EPI)) || (!INIT_OK && idx == AW'(3))) begin
      w = TW'(nfa_pkg::ALLOC_BIT);
    end
    return w;
  endfunction

  // Decoded read data and the conditions of the sequencer.
  logic [PW-1:0] rsize, need_calc, ext, prv, nxt;
  logic          ralloc, accept, out_free, walk_stop, fit, grow_ok, free_pre, free_ok;
  logic          split, case_none;

  assign rsize  = PW'(rdata & ~TW'(nfa_pkg::SIZE_LOW_MASK));
  assign ralloc = rdata[0];
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign need_calc = (request_bytes <= 16'(nfa_pkg::SMALL_REQ)) ? PW'(nfa_pkg::MIN_BLOCK) :
                     ((PW'(request_bytes) + PW'(nfa_pkg::OVERHEAD_UP)) &
                      ~PW'(nfa_pkg::SIZE_LOW_MASK));
  assign walk_stop = (cnt == CW'(LIMIT)) || (phase && bp == rover);
  assign fit       = !ralloc && need <= rsize;
  assign ext       = (need > PW'(CHUNK_R)) ? need : PW'(CHUNK_R);
  assign grow_ok   = ext <= PW'(HEAP_BYTES) - heap_top;
  assign free_pre  = block_address[2:0] == 3'd0 &&
                     PW'(block_address) >= PW'(nfa_pkg::FIRST_PAYLOAD) &&
                     PW'(block_address) < heap_top;
  assign free_ok   = ralloc && rsize >= PW'(nfa_pkg::MIN_BLOCK) && rsize <= heap_top - bp;
  assign prv       = bp - pfoot;
  assign nxt       = bp + size;
  assign split     = size >= need && (size - need) >= PW'(nfa_pkg::MIN_BLOCK);
  assign case_none = palloc && nalloc;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      nfa_pkg::ST_CLEAR: if (clr_idx == AW'(DEPTH - 1)) state_next = nfa_pkg::ST_IDLE;
      nfa_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode == nfa_pkg::MODE_FREE) begin
            state_next = free_pre ? nfa_pkg::ST_FRD : nfa_pkg::ST_DONE;
          end else begin
            state_next = (request_bytes == 16'd0) ? nfa_pkg::ST_DONE : nfa_pkg::ST_SRD;
          end
        end
      end
      nfa_pkg::ST_SRD: begin
        if (!walk_stop) state_next = nfa_pkg::ST_SCHK;
        else if (phase) state_next = nfa_pkg::ST_GROW;
      end
      nfa_pkg::ST_SCHK: begin
        if (rsize == '0) state_next = phase ? nfa_pkg::ST_GROW : nfa_pkg::ST_SRD;
        else if (fit) state_next = nfa_pkg::ST_CARVE;
        else state_next = nfa_pkg::ST_SRD;
      end
      nfa_pkg::ST_GROW: state_next = grow_ok ? nfa_pkg::ST_GWR : nfa_pkg::ST_DONE;
      nfa_pkg::ST_GWR:  if (wstep == 2'd2) state_next = nfa_pkg::ST_MR1;
      nfa_pkg::ST_FRD:  state_next = nfa_pkg::ST_FCHK;
      nfa_pkg::ST_FCHK: state_next = free_ok ? nfa_pkg::ST_FWR : nfa_pkg::ST_DONE;
      nfa_pkg::ST_FWR:  if (wstep == 2'd1) state_next = nfa_pkg::ST_MR1;
      nfa_pkg::ST_MR1:  state_next = nfa_pkg::ST_MR2;
      nfa_pkg::ST_MR2:  state_next = nfa_pkg::ST_MR3;
      nfa_pkg::ST_MR3:  state_next = palloc ? nfa_pkg::ST_MWR : nfa_pkg::ST_MR4;
      nfa_pkg::ST_MR4:  state_next = nfa_pkg::ST_MWR;
      nfa_pkg::ST_MWR: begin
        if (case_none || wstep == 2'd1) begin
          state_next = is_grow ? nfa_pkg::ST_CARVE : nfa_pkg::ST_DONE;
        end
      end
      nfa_pkg::ST_CARVE: begin
        if ((split && wstep == 2'd3) || (!split && wstep == 2'd1)) begin
          state_next = nfa_pkg::ST_DONE;
        end
      end
      nfa_pkg::ST_DONE: if (out_free) state_next = nfa_pkg::ST_IDLE;
      default: state_next = nfa_pkg::ST_CLEAR;
    endcase
  end

  // Tag memory port and handshake outputs.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_byte  = '0;
    mem_wdata = '0;
    in_stall  = (state != nfa_pkg::ST_IDLE);
    unique case (state)
      nfa_pkg::ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = init_word(clr_idx);
      end
      nfa_pkg::ST_SRD: begin
        mem_en   = !walk_stop;
        mem_byte = bp - PW'(4);
      end
      nfa_pkg::ST_FRD: begin
        mem_en   = 1'b1;
        mem_byte = bp - PW'(4);
      end
      nfa_pkg::ST_GWR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        case (wstep)
          2'd0: begin
            mem_byte  = bp - PW'(4);
            mem_wdata = TW'(size);
          end
          2'd1: begin
            mem_byte  = nxt - PW'(8);
            mem_wdata = TW'(size);
          end
          default: begin
            mem_byte  = nxt - PW'(4);
            mem_wdata = TW'(nfa_pkg::ALLOC_BIT);
          end
        endcase
      end
      nfa_pkg::ST_FWR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = TW'(size);
        mem_byte  = (wstep == 2'd0) ? bp - PW'(4) : nxt - PW'(8);
      end
      nfa_pkg::ST_MR1: begin
        mem_en   = 1'b1;
        mem_byte = bp - PW'(8);
      end
      nfa_pkg::ST_MR2: begin
        mem_en   = 1'b1;
        mem_byte = nxt - PW'(4);
      end
      nfa_pkg::ST_MR3: begin
        mem_en   = !palloc;
        mem_byte = prv - PW'(4);
      end
      nfa_pkg::ST_MWR: begin
        mem_en    = !case_none;
        mem_we    = !case_none;
        mem_wdata = TW'(tot);
        if (palloc) begin
          mem_byte = (wstep == 2'd0) ? bp - PW'(4) : bp + tot - PW'(8);
        end else if (nalloc) begin
          mem_byte = (wstep == 2'd0) ? nxt - PW'(8) : prv - PW'(4);
        end else begin
          mem_byte = (wstep == 2'd0) ? prv - PW'(4) : nxt + nsize - PW'(8);
        end
      end
      nfa_pkg::ST_CARVE: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        if (split) begin
          case (wstep)
            2'd0: begin
              mem_byte  = bp - PW'(4);
              mem_wdata = TW'(need | PW'(nfa_pkg::ALLOC_BIT));
            end
            2'd1: begin
              mem_byte  = bp + need - PW'(8);
              mem_wdata = TW'(need | PW'(nfa_pkg::ALLOC_BIT));
            end
            2'd2: begin
              mem_byte  = bp + need - PW'(4);
              mem_wdata = TW'(size - need);
            end
            default: begin
              mem_byte  = nxt - PW'(8);
              mem_wdata = TW'(size - need);
            end
          endcase
        end else begin
          mem_byte  = (wstep == 2'd0) ? bp - PW'(4) : nxt - PW'(8);
          mem_wdata = TW'(size | PW'(nfa_pkg::ALLOC_BIT));
        end
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
    mem_idx = (state == nfa_pkg::ST_CLEAR) ? clr_idx : mem_byte[AW+1:2];
  end

  nfa_tag_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .TW   (TW)
  ) u_tag_ram (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_idx),
    .wdata(mem_wdata),
    .rdata(rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer datapath: pointers, sizes, counters and heap registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_top <= PW'(TOP0);
      rover    <= PW'(ROVER0);
      clr_idx  <= '0;
      cnt      <= '0;
      wstep    <= '0;
      phase    <= 1'b0;
      is_grow  <= 1'b0;
    end else begin
      case (state)
        nfa_pkg::ST_CLEAR: clr_idx <= clr_idx + AW'(1);
        nfa_pkg::ST_IDLE: begin
          if (accept) begin
            bp         <= (mode == nfa_pkg::MODE_FREE) ? PW'(block_address) : rover;
            need       <= need_calc;
            cnt        <= '0;
            phase      <= 1'b0;
            wstep      <= '0;
            is_grow    <= 1'b0;
            res_addr   <= '0;
            res_status <= (mode == nfa_pkg::MODE_FREE) ?
                          (free_pre ? nfa_pkg::STAT_OK : nfa_pkg::STAT_IGNORED) :
                          ((request_bytes == 16'd0) ? nfa_pkg::STAT_IGNORED :
                           nfa_pkg::STAT_OK);
          end
        end
        nfa_pkg::ST_SRD: begin
          if (walk_stop && !phase) begin
            phase <= 1'b1;
            bp    <= PW'(nfa_pkg::HEAP_BASE);
            cnt   <= '0;
          end
        end
        nfa_pkg::ST_SCHK: begin
          if (rsize == '0) begin
            if (!phase) begin
              phase <= 1'b1;
              bp    <= PW'(nfa_pkg::HEAP_BASE);
              cnt   <= '0;
            end
          end else if (fit) begin
            size  <= rsize;
            wstep <= '0;
          end else begin
            bp  <= bp + rsize;
            cnt <= cnt + CW'(1);
          end
        end
        nfa_pkg::ST_GROW: begin
          if (grow_ok) begin
            bp       <= heap_top;
            size     <= ext;
            heap_top <= heap_top + ext;
            wstep    <= '0;
            is_grow  <= 1'b1;
          end else begin
            res_status <= nfa_pkg::STAT_NO_MEM;
            res_addr   <= '0;
          end
        end
        nfa_pkg::ST_GWR: wstep <= (wstep == 2'd2) ? 2'd0 : wstep + 2'd1;
        nfa_pkg::ST_FCHK: begin
          size  <= rsize;
          wstep <= '0;
          if (!free_ok) res_status <= nfa_pkg::STAT_IGNORED;
        end
        nfa_pkg::ST_FWR: wstep <= (wstep == 2'd1) ? 2'd0 : wstep + 2'd1;
        nfa_pkg::ST_MR2: begin
          pfoot  <= rsize;
          palloc <= ralloc;
        end
        nfa_pkg::ST_MR3: begin
          nsize  <= rsize;
          nalloc <= ralloc;
          tot    <= size + rsize;
          wstep  <= '0;
        end
        nfa_pkg::ST_MR4: begin
          tot <= nalloc ? size + rsize : size + rsize + nsize;
        end
        nfa_pkg::ST_MWR: begin
          if (case_none || wstep == 2'd1) begin
            wstep <= '0;
            if (!palloc) begin
              bp    <= prv;
              rover <= prv;
            end else begin
              rover <= bp;
            end
            if (!case_none) size <= tot;
          end else begin
            wstep <= wstep + 2'd1;
          end
        end
        nfa_pkg::ST_CARVE: begin
          wstep    <= wstep + 2'd1;
          res_addr <= bp;
        end
        default: begin
          wstep <= wstep;
        end
      endcase
    end
  end

  // Output register: a finished result waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == nfa_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == nfa_pkg::ST_DONE && out_free) begin
      payload_address <= res_addr[15:0];
      status          <= res_status;
    end
  end

  // Checks on the heap registers, the search walk and the output status.
  `NFA_ASSERT_ALWAYS(a_top_bound, heap_top <= PW'(HEAP_BYTES), "heap top beyond heap")
  `NFA_ASSERT_ALWAYS(a_rover_align, rover[2:0] == 3'd0, "rover not 8-byte aligned")
  `NFA_ASSERT_ALWAYS(a_walk_bound, cnt <= CW'(LIMIT), "search walk passed its limit")
  `NFA_ASSERT_NEXT(a_top_hold, state != nfa_pkg::ST_GROW, $stable(heap_top), "heap top moved")
  `NFA_ASSERT_ALWAYS(a_status_code, !out_valid || status <= nfa_pkg::STAT_NO_MEM, "bad status")

endmodule
`default_nettype wire
